// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the NCO mixer RTL.
// Expects aclk and aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while in reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never be true out of reset
`define ASSERT_NEVER(lbl, bad, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(bad)) \
        else $error(msg);

`endif

// ===== rtl/core/nco_mix_pkg.sv =====
// Package for the NCO complex mixer: widths, types, register codes,
// sine table built at elaboration, rounding and saturation helpers.
// No dependencies.
`default_nettype none

package nco_mix_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    // register file
    localparam int INC_W      = 32;
    localparam int AMP_W      = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_INC  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIX_ENABLE = 2'd2;

    // datapath widths
    localparam int QUARTER    = 1 << (TABLE_ADDR_BITS - 2);
    localparam int QIDX_W     = TABLE_ADDR_BITS - 1;
    localparam int TAB_W      = 17;                 // -32768..32768
    localparam int PROD_W     = TAB_W + AMP_W + 1;  // table * amplitude
    localparam int MIX_SHIFT  = 15;
    localparam int C_W        = PROD_W - MIX_SHIFT; // scaled tone
    localparam int MIX_W      = SAMPLE_BITS + C_W;  // sample * tone
    localparam int ACC_W      = (MIX_W > PROD_W) ? MIX_W + 1 : PROD_W + 1;
    localparam int TONE_SHIFT = 31 - SAMPLE_BITS;
    localparam int DATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int NSTG       = 5;                  // back-end stages

    // request queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [TABLE_ADDR_BITS-1:0]    addr_t;
    typedef logic [QIDX_W-1:0]             qidx_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [TAB_W-1:0]       tab_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [C_W-1:0]         coef_t;
    typedef logic signed [MIX_W-1:0]       mix_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [Q_PTR_W-1:0]            qptr_t;
    typedef logic [Q_CNT_W-1:0]            qcnt_t;
    typedef tab_t                          qtab_t [QUARTER];

    typedef struct packed {
        addr_t   addr;
        sample_t in_i;
        sample_t in_q;
        logic    last;
    } item_t;

    typedef struct packed {
        logic [INC_W-1:0] phase_inc;
        logic [AMP_W-1:0] amplitude;
        logic             mix_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{phase_inc: '0, amplitude: 16'h8000, mix_enable: 1'b1};

    localparam acc_t RND_MIX  = acc_t'(1) <<< (MIX_SHIFT - 1);
    localparam acc_t RND_TONE = acc_t'(1) <<< (TONE_SHIFT - 1);
    localparam acc_t SAT_HI   = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
    localparam acc_t SAT_LO   = -SAT_HI - acc_t'(1);

    // First-quadrant sine in Q15, Taylor series to x^15 on a Q30 angle
    function automatic tab_t quarter_sine(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        longint      sum;
        longint      r;
        x   = (64'd1686629713 * 64'(j) + 64'(QUARTER / 2)) / 64'(QUARTER);
        x2  = (x * x + (64'd1 << 29)) >> 30;
        mag = x;
        sum = longint'(x);
        mag = ((mag * x2) >> 30) / 64'd6;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd20;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd42;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd72;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd110;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd156;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd210;
        sum = sum - longint'(mag);
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 32768) begin
            r = 32768;
        end
        return tab_t'(r);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k < QUARTER; k++) begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam qtab_t QSINE     = build_qtab();
    localparam tab_t  SINE_PEAK = quarter_sine(QUARTER);

    // Full-wave sine from the quarter table by mirroring
    function automatic tab_t sine_lookup(input addr_t k);
        logic [1:0]                     quad;
        logic [TABLE_ADDR_BITS-3:0]     j;
        qidx_t                          idx;
        tab_t                           v;
        quad = k[TABLE_ADDR_BITS-1 -: 2];
        j    = k[TABLE_ADDR_BITS-3:0];
        idx  = quad[0] ? (qidx_t'(QUARTER) - {1'b0, j}) : {1'b0, j};
        v    = idx[QIDX_W-1] ? SINE_PEAK : QSINE[idx[QIDX_W-2:0]];
        return quad[1] ? -v : v;
    endfunction

    function automatic sample_t sat_sample(input acc_t v);
        if (v > SAT_HI) begin
            return sample_t'(SAT_HI);
        end
        if (v < SAT_LO) begin
            return sample_t'(SAT_LO);
        end
        return sample_t'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nco_mix_front.sv =====
// Front end: takes sample requests, tags each with the table address of the
// current phase and advances the phase accumulator. Uses nco_mix_pkg.
`default_nettype none
`include "assert_macros.svh"

module nco_mix_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire nco_mix_pkg::sample_t            in_i,
    input  wire nco_mix_pkg::sample_t            in_q,
    input  wire logic                            in_last,
    input  wire logic [nco_mix_pkg::INC_W-1:0]   phase_inc,
    input  wire logic                            q_full,
    output      logic                            q_push,
    output      nco_mix_pkg::item_t              q_item
);

    nco_mix_pkg::phase_t phase_reg;
    nco_mix_pkg::phase_t phase_next;
    logic                accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // address comes from the phase before this sample's advance
    always_comb begin
        q_item.addr = phase_reg[nco_mix_pkg::PHASE_BITS-1 -: nco_mix_pkg::TABLE_ADDR_BITS];
        q_item.in_i = in_i;
        q_item.in_q = in_q;
        q_item.last = in_last;
    end

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            phase_next = phase_reg + nco_mix_pkg::phase_t'($signed(phase_inc));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    `ASSERT_CLK(a_phase_hold, !accept |=> $stable(phase_reg), "phase moved without a request")

endmodule

`default_nettype wire

// ===== rtl/core/nco_mix_fifo.sv =====
// Short request queue between front and back end.
// Uses nco_mix_pkg for the item type and depth.
`default_nettype none
`include "assert_macros.svh"

module nco_mix_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               wr_en,
    input  wire nco_mix_pkg::item_t wr_item,
    output      logic               full,
    input  wire logic               rd_en,
    output      nco_mix_pkg::item_t rd_item,
    output      logic               not_empty
);

    nco_mix_pkg::item_t mem_reg [nco_mix_pkg::Q_DEPTH];
    nco_mix_pkg::qptr_t wr_ptr_reg, wr_ptr_next;
    nco_mix_pkg::qptr_t rd_ptr_reg, rd_ptr_next;
    nco_mix_pkg::qcnt_t count_reg, count_next;

    assign full      = (count_reg == nco_mix_pkg::qcnt_t'(nco_mix_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + nco_mix_pkg::qptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + nco_mix_pkg::qptr_t'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + nco_mix_pkg::qcnt_t'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - nco_mix_pkg::qcnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `ASSERT_NEVER(a_q_overflow, wr_en && full, "queue written while full")
    `ASSERT_NEVER(a_q_underflow, rd_en && !not_empty, "queue read while empty")

endmodule

`default_nettype wire

// ===== rtl/core/nco_mix_back.sv =====
// Back end: five-stage datapath. Table lookup, amplitude scaling, rounding,
// complex multiply and saturation, or the tone alone when mixing is off. Uses nco_mix_pkg.
`default_nettype none
`include "assert_macros.svh"

module nco_mix_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire nco_mix_pkg::item_t            q_item,
    output      logic                          q_pop,
    input  wire logic [nco_mix_pkg::AMP_W-1:0] amplitude,
    input  wire logic                          mix_enable,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      nco_mix_pkg::sample_t          out_i,
    output      nco_mix_pkg::sample_t          out_q,
    output      logic                          out_last
);

    logic [nco_mix_pkg::NSTG-1:0] valid_reg, valid_next;
    logic                         en;
    logic signed [nco_mix_pkg::AMP_W:0] amp_s;

    // stage 1: table
    nco_mix_pkg::tab_t    s1_sin_reg, s1_cos_reg;
    nco_mix_pkg::sample_t s1_i_reg, s1_q_reg;
    logic                 s1_last_reg;
    // stage 2: scaled table
    nco_mix_pkg::prod_t   s2_psin_reg, s2_pcos_reg;
    nco_mix_pkg::sample_t s2_i_reg, s2_q_reg;
    logic                 s2_last_reg;
    // stage 3: rounded tone
    nco_mix_pkg::coef_t   s3_s_reg, s3_c_reg;
    nco_mix_pkg::sample_t s3_tone_i_reg, s3_tone_q_reg;
    nco_mix_pkg::sample_t s3_i_reg, s3_q_reg;
    logic                 s3_last_reg;
    // stage 4: mixer products
    nco_mix_pkg::mix_t    s4_ic_reg, s4_qs_reg, s4_is_reg, s4_qc_reg;
    nco_mix_pkg::sample_t s4_tone_i_reg, s4_tone_q_reg;
    logic                 s4_last_reg;
    // stage 5: output register
    nco_mix_pkg::sample_t out_i_reg, out_q_reg;
    logic                 out_last_reg;

    nco_mix_pkg::acc_t c_sum, s_sum, c_rnd, s_rnd;
    nco_mix_pkg::acc_t ti_sum, tq_sum, ti_rnd, tq_rnd;
    nco_mix_pkg::acc_t mi_sum, mq_sum, mi_rnd, mq_rnd;
    nco_mix_pkg::sample_t out_i_next, out_q_next;

    // whole pipe moves unless the output is held
    assign en       = !valid_reg[nco_mix_pkg::NSTG-1] || m_tready;
    assign q_pop    = q_valid && en;
    assign m_tvalid = valid_reg[nco_mix_pkg::NSTG-1];
    assign out_i    = out_i_reg;
    assign out_q    = out_q_reg;
    assign out_last = out_last_reg;
    assign amp_s    = $signed({1'b0, amplitude});

    assign valid_next = en ? {valid_reg[nco_mix_pkg::NSTG-2:0], q_pop} : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        c_sum  = nco_mix_pkg::acc_t'(s2_pcos_reg) + nco_mix_pkg::RND_MIX;
        s_sum  = nco_mix_pkg::acc_t'(s2_psin_reg) + nco_mix_pkg::RND_MIX;
        c_rnd  = c_sum >>> nco_mix_pkg::MIX_SHIFT;
        s_rnd  = s_sum >>> nco_mix_pkg::MIX_SHIFT;
        ti_sum = nco_mix_pkg::acc_t'(s2_pcos_reg) + nco_mix_pkg::RND_TONE;
        tq_sum = nco_mix_pkg::acc_t'(s2_psin_reg) + nco_mix_pkg::RND_TONE;
        ti_rnd = ti_sum >>> nco_mix_pkg::TONE_SHIFT;
        tq_rnd = tq_sum >>> nco_mix_pkg::TONE_SHIFT;
    end

    always_comb begin
        mi_sum = nco_mix_pkg::acc_t'(s4_ic_reg) - nco_mix_pkg::acc_t'(s4_qs_reg)
                 + nco_mix_pkg::RND_MIX;
        mq_sum = nco_mix_pkg::acc_t'(s4_is_reg) + nco_mix_pkg::acc_t'(s4_qc_reg)
                 + nco_mix_pkg::RND_MIX;
        mi_rnd = mi_sum >>> nco_mix_pkg::MIX_SHIFT;
        mq_rnd = mq_sum >>> nco_mix_pkg::MIX_SHIFT;
        if (mix_enable) begin
            out_i_next = nco_mix_pkg::sat_sample(mi_rnd);
            out_q_next = nco_mix_pkg::sat_sample(mq_rnd);
        end else begin
            out_i_next = s4_tone_i_reg;
            out_q_next = s4_tone_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sin_reg  <= nco_mix_pkg::sine_lookup(q_item.addr);
            s1_cos_reg  <= nco_mix_pkg::sine_lookup(
                               q_item.addr + nco_mix_pkg::addr_t'(nco_mix_pkg::QUARTER));
            s1_i_reg    <= q_item.in_i;
            s1_q_reg    <= q_item.in_q;
            s1_last_reg <= q_item.last;

            s2_psin_reg <= nco_mix_pkg::prod_t'(s1_sin_reg) * nco_mix_pkg::prod_t'(amp_s);
            s2_pcos_reg <= nco_mix_pkg::prod_t'(s1_cos_reg) * nco_mix_pkg::prod_t'(amp_s);
            s2_i_reg    <= s1_i_reg;
            s2_q_reg    <= s1_q_reg;
            s2_last_reg <= s1_last_reg;

            s3_c_reg      <= c_rnd[nco_mix_pkg::C_W-1:0];
            s3_s_reg      <= s_rnd[nco_mix_pkg::C_W-1:0];
            s3_tone_i_reg <= nco_mix_pkg::sat_sample(ti_rnd);
            s3_tone_q_reg <= nco_mix_pkg::sat_sample(tq_rnd);
            s3_i_reg      <= s2_i_reg;
            s3_q_reg      <= s2_q_reg;
            s3_last_reg   <= s2_last_reg;

            s4_ic_reg     <= nco_mix_pkg::mix_t'(s3_i_reg) * nco_mix_pkg::mix_t'(s3_c_reg);
            s4_qs_reg     <= nco_mix_pkg::mix_t'(s3_q_reg) * nco_mix_pkg::mix_t'(s3_s_reg);
            s4_is_reg     <= nco_mix_pkg::mix_t'(s3_i_reg) * nco_mix_pkg::mix_t'(s3_s_reg);
            s4_qc_reg     <= nco_mix_pkg::mix_t'(s3_q_reg) * nco_mix_pkg::mix_t'(s3_c_reg);
            s4_tone_i_reg <= s3_tone_i_reg;
            s4_tone_q_reg <= s3_tone_q_reg;
            s4_last_reg   <= s3_last_reg;

            out_i_reg    <= out_i_next;
            out_q_reg    <= out_q_next;
            out_last_reg <= s4_last_reg;
        end
    end

    `ASSERT_CLK(a_pipe_hold, !en |=> $stable(valid_reg), "pipe advanced during output stall")

endmodule

`default_nettype wire

// ===== rtl/core/nco_complex_mixer_top.sv =====
// Top level of the NCO complex mixer: register file, front end, request
// queue and back end. Uses nco_mix_pkg, nco_mix_front, nco_mix_fifo, nco_mix_back.
//
//  Channel   Dir  Handshake             Payload
//  s_*       in   s_tvalid / s_tready   s_tdata = {in_q, in_i}, s_tlast = in_last
//  m_*       out  m_tvalid / m_tready   m_tdata = {out_q, out_i}, m_tlast = out_last
//  cfg_*     in   cfg_wr_en             cfg_addr = register index, cfg_wdata
//
// Sustained rate is one sample per clock while m_tready stays high: the phase
// accumulator does a single add per request and the back end is a five-stage
// pipeline. A request passes through the queue and the back-end stages before
// it raises m_tvalid; its result is taken while m_tready is high.
// Reset is synchronous, active low; it clears the phase to zero and loads the
// register defaults (increment 0, unity amplitude, mix mode).
// A stalled output freezes the back end; the front keeps taking requests until
// the four-entry queue fills, then drops s_tready.
`default_nettype none

module nco_complex_mixer_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input samples
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic [nco_mix_pkg::DATA_W-1:0]       s_tdata,   // in_i, in_q
    input  wire logic                                 s_tlast,   // in_last
    // results
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    output      logic [nco_mix_pkg::DATA_W-1:0]       m_tdata,   // out_i, out_q
    output      logic                                 m_tlast,   // out_last
    // register writes
    input  wire logic                                 cfg_wr_en,
    input  wire logic [nco_mix_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [nco_mix_pkg::CFG_W-1:0]        cfg_wdata
);

    nco_mix_pkg::cfg_t    cfg_reg, cfg_next;
    nco_mix_pkg::item_t   push_item, pop_item;
    logic                 q_push, q_full, q_pop, q_valid;
    nco_mix_pkg::sample_t res_i, res_q;

    // Register file; host must write it only with no request in flight; unenforced.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                nco_mix_pkg::REG_PHASE_INC: begin
                    cfg_next.phase_inc = cfg_wdata[nco_mix_pkg::INC_W-1:0];
                end
                nco_mix_pkg::REG_AMPLITUDE: begin
                    cfg_next.amplitude = cfg_wdata[nco_mix_pkg::AMP_W-1:0];
                end
                nco_mix_pkg::REG_MIX_ENABLE: begin
                    cfg_next.mix_enable = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= nco_mix_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: phase tagging
    nco_mix_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_i      (s_tdata[nco_mix_pkg::SAMPLE_BITS-1:0]),
        .in_q      (s_tdata[2*nco_mix_pkg::SAMPLE_BITS-1:nco_mix_pkg::SAMPLE_BITS]),
        .in_last   (s_tlast),
        .phase_inc (cfg_reg.phase_inc),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // Queue decouples front and back
    nco_mix_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (q_push),
        .wr_item   (push_item),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_item   (pop_item),
        .not_empty (q_valid)
    );

    // Back: tone generation and mixing
    nco_mix_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (pop_item),
        .q_pop      (q_pop),
        .amplitude  (cfg_reg.amplitude),
        .mix_enable (cfg_reg.mix_enable),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_i      (res_i),
        .out_q      (res_q),
        .out_last   (m_tlast)
    );

    // pack results, i in the low half, zero fill to whole bytes
    assign m_tdata = nco_mix_pkg::DATA_W'({res_q, res_i});

endmodule

`default_nettype wire
